// ----- design/frs_pkg.sv -----
// shared types and constants for the fenwick range-sum block
package frs_pkg;

  localparam int NUM_ELEMS_DEF = 1024;
  localparam int IDX_W         = 10;
  localparam int VAL_W         = 32;
  localparam int SUM_W         = 64;

  // request kinds
  localparam logic REQ_SET   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_RD,
    ST_SET_DIFF,
    ST_TREE_RD,
    ST_TREE_WR,
    ST_Q_RD,
    ST_Q_ACC,
    ST_Q_OUT
  } state_t;

endpackage

// ----- design/fenwick_range_sum_point_set.sv -----
// fenwick tree over signed 32-bit entries: point set and range-sum query
// Steps: a set reads the old value, writes the new one and forms the difference, then
//   reads and updates each node on its i|(i+1) chain; a query adds the nodes of prefix
//   right+1, subtracts those of prefix left, then presents its result word.
// Throughput: one request at a time; each tree node takes a read state and then a write
//   or an accumulate state on the tree memory. Reset: synchronous rst starts a clearing
//   pass that zeroes both memories; no request word is taken until it is done.
module fenwick_range_sum_point_set
  import frs_pkg::*;
#(
  parameter int NUM_ELEMS = NUM_ELEMS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  logic                    req_type,
  input  logic [IDX_W-1:0]        index_a,
  input  logic [IDX_W-1:0]        index_b,
  input  logic signed [VAL_W-1:0] new_val,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  output logic signed [SUM_W-1:0] range_sum
);

  localparam int AW = (NUM_ELEMS > 1) ? $clog2(NUM_ELEMS) : 1;
  localparam int NW = AW + 1;
  localparam logic [NW-1:0] N_LIM  = NW'(NUM_ELEMS);
  localparam logic [NW-1:0] N_LAST = NW'(NUM_ELEMS - 1);

  state_t state, state_next;

  // memories
  logic [SUM_W-1:0] tree_mem [NUM_ELEMS];
  logic [VAL_W-1:0] val_mem  [NUM_ELEMS];
  logic [SUM_W-1:0] tree_rdata;
  logic [VAL_W-1:0] val_rdata;
  logic [AW-1:0]    tree_raddr;
  logic [AW-1:0]    tree_waddr;
  logic [SUM_W-1:0] tree_wdata;
  logic             tree_we;
  logic [AW-1:0]    val_waddr;
  logic [VAL_W-1:0] val_wdata;
  logic             val_we;

  // datapath registers
  logic [AW-1:0]    clr;
  logic [AW-1:0]    pos;
  logic [VAL_W-1:0] val_new;
  logic [SUM_W-1:0] diff;
  logic [NW-1:0]    walk;
  logic [NW-1:0]    left;
  logic             phase;
  logic [SUM_W-1:0] acc;

  logic          req_acc;
  logic          rsp_free;
  logic          set_in_range;
  logic [NW-1:0] a_clamp;
  logic [NW-1:0] b_clamp;
  logic [NW-1:0] walk_dec;
  logic [NW-1:0] walk_up;
  logic [SUM_W-1:0] diff_calc;

  assign req_stall = (state != ST_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  assign set_in_range = (32'(index_a) < 32'(NUM_ELEMS));
  assign a_clamp = (32'(index_a) >= 32'(NUM_ELEMS)) ? N_LAST : NW'(index_a);
  assign b_clamp = (32'(index_b) >= 32'(NUM_ELEMS)) ? N_LAST : NW'(index_b);

  assign walk_dec  = walk - NW'(1);
  assign walk_up   = walk | (walk + NW'(1));
  assign diff_calc = {{(SUM_W-VAL_W){val_new[VAL_W-1]}}, val_new}
                   - {{(SUM_W-VAL_W){val_rdata[VAL_W-1]}}, val_rdata};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr == N_LAST[AW-1:0]) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_acc) begin
          if (req_type == REQ_QUERY) state_next = ST_Q_RD;
          else if (set_in_range)     state_next = ST_SET_RD;
        end
      end
      ST_SET_RD:   state_next = ST_SET_DIFF;
      ST_SET_DIFF: state_next = ST_TREE_RD;
      ST_TREE_RD:  state_next = ST_TREE_WR;
      ST_TREE_WR: begin
        state_next = (walk_up >= N_LIM) ? ST_IDLE : ST_TREE_RD;
      end
      ST_Q_RD: begin
        if (walk != '0)  state_next = ST_Q_ACC;
        else if (phase)  state_next = ST_Q_OUT;
      end
      ST_Q_ACC: state_next = ST_Q_RD;
      ST_Q_OUT: begin
        if (rsp_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    tree_raddr = walk[AW-1:0];
    tree_waddr = walk[AW-1:0];
    tree_wdata = tree_rdata + diff;
    tree_we    = 1'b0;
    val_waddr  = pos;
    val_wdata  = val_new;
    val_we     = 1'b0;
    case (state)
      ST_CLEAR: begin
        tree_waddr = clr;
        tree_wdata = '0;
        tree_we    = 1'b1;
        val_waddr  = clr;
        val_wdata  = '0;
        val_we     = 1'b1;
      end
      ST_SET_DIFF: val_we = 1'b1;
      ST_TREE_WR:  tree_we = 1'b1;
      ST_Q_RD:     tree_raddr = walk_dec[AW-1:0];
      default: begin
        tree_we = 1'b0;
      end
    endcase
  end

  // memory arrays
  always_ff @(posedge clk) begin
    if (tree_we) tree_mem[tree_waddr] <= tree_wdata;
    tree_rdata <= tree_mem[tree_raddr];
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_waddr] <= val_wdata;
    val_rdata <= val_mem[pos];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr <= clr + AW'(1);
      if (state == ST_Q_OUT && rsp_free) rsp_valid <= 1'b1;
      else if (!rsp_stall)               rsp_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_acc) begin
          pos     <= a_clamp[AW-1:0];
          val_new <= new_val;
          left    <= a_clamp;
          walk    <= b_clamp + NW'(1);
          phase   <= 1'b0;
          acc     <= '0;
        end
      end
      ST_SET_DIFF: begin
        diff <= diff_calc;
        walk <= NW'(pos);
      end
      ST_TREE_WR: walk <= walk_up;
      ST_Q_RD: begin
        if (walk == '0 && !phase) begin
          walk  <= left;
          phase <= 1'b1;
        end
      end
      ST_Q_ACC: begin
        acc  <= phase ? (acc - tree_rdata) : (acc + tree_rdata);
        walk <= walk & walk_dec;
      end
      ST_Q_OUT: begin
        if (rsp_free) range_sum <= acc;
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  // checks
  a_reset_clear: assert property (@(posedge clk) $fell(rst) |-> state == ST_CLEAR)
    else $error("clearing pass not started after reset");

  a_tree_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_TREE_WR |-> walk < N_LIM)
    else $error("tree update beyond last node");

  a_query_start: assert property (@(posedge clk) disable iff (rst)
    req_acc && req_type == REQ_QUERY |=> state == ST_Q_RD && !phase && acc == '0)
    else $error("query did not start in the right-prefix phase");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    state == ST_Q_OUT && rsp_free |=> rsp_valid && state == ST_IDLE)
    else $error("finished query word not presented");

endmodule
